// ===== design/rtcp_pkg.sv =====
`timescale 1ns / 1ps

package rtcp_types_pkg;

    // Default limit on reported packets per payload; the counter is sized for the top of the range
    localparam int MaxPacketsDefault = 16;
    localparam int SeenWidth         = 5;
    localparam int OffsetWidth       = 18;
    localparam int NumWords          = 6;

    // Configuration register indexes
    localparam logic CfgSenderReport = 1'b0;
    localparam logic CfgSourceDesc   = 1'b1;

    localparam logic [7:0] SenderReportReset = 8'd200;
    localparam logic [7:0] SourceDescReset   = 8'd202;

    // Packet byte offsets of interest
    localparam logic [OffsetWidth-1:0] OffHeader   = 18'd0;
    localparam logic [OffsetWidth-1:0] OffType     = 18'd1;
    localparam logic [OffsetWidth-1:0] OffLenHigh  = 18'd2;
    localparam logic [OffsetWidth-1:0] OffLenLow   = 18'd3;
    localparam logic [OffsetWidth-1:0] OffSrEnd    = 18'd28;
    localparam logic [OffsetWidth-1:0] OffSdesEnd  = 18'd8;
    localparam logic [OffsetWidth-1:0] OffItemType = 18'd8;
    localparam logic [OffsetWidth-1:0] OffItemLen  = 18'd9;

    localparam int ResultBits = 244;
    localparam int TdataBits  = 248;

    // Packed; first field in the highest bits
    typedef struct packed {
        logic [3:0]  packet_index;
        logic [7:0]  item_length;
        logic [7:0]  item_type;
        logic [31:0] sender_octets;
        logic [31:0] sender_packets;
        logic [31:0] media_timestamp;
        logic [31:0] ntp_low;
        logic [31:0] ntp_high;
        logic [31:0] source_id;
        logic [15:0] length_words;
        logic [7:0]  packet_type;
        logic [7:0]  header_byte;
    } t_result;

    typedef struct packed {
        logic [7:0] sender_report_type;
        logic [7:0] source_desc_type;
    } t_cfg;

endpackage

// ===== design/rtcp_parser.sv =====
`timescale 1ns / 1ps

module rtcp_parser
    import rtcp_types_pkg::*;
#(
    parameter int MAX_PACKETS = MaxPacketsDefault
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_advance,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_payload,
    input  t_cfg       i_cfg,
    output logic       o_emit,
    output t_result    o_result
);

    logic [OffsetWidth-1:0] r_offset, n_offset;
    logic [SeenWidth-1:0]   r_seen, n_seen;
    logic [7:0]             r_header, n_header;
    logic [7:0]             r_type, n_type;
    logic [15:0]            r_length, n_length;
    logic [31:0]            r_words [NumWords];
    logic [31:0]            n_words [NumWords];
    logic [7:0]             r_item_type, n_item_type;
    logic [7:0]             r_item_len, n_item_len;

    logic                   done;
    logic [2:0]             sr_word;
    logic [OffsetWidth-1:0] last_off;

    assign sr_word  = r_offset[4:2] - 3'd1;
    assign last_off = {n_length, 2'b11};

    always_comb begin
        n_header    = r_header;
        n_type      = r_type;
        n_length    = r_length;
        n_item_type = r_item_type;
        n_item_len  = r_item_len;
        for (int k = 0; k < NumWords; k++) begin
            n_words[k] = r_words[k];
        end

        if (r_offset == OffHeader) begin
            for (int k = 0; k < NumWords; k++) begin
                n_words[k] = '0;
            end
            n_item_type = '0;
            n_item_len  = '0;
            n_header    = i_data_byte;
        end else if (r_offset == OffType) begin
            n_type = i_data_byte;
        end else if (r_offset == OffLenHigh) begin
            n_length = {i_data_byte, 8'h00};
        end else if (r_offset == OffLenLow) begin
            n_length = {r_length[15:8], i_data_byte};
        end else if (r_type == i_cfg.sender_report_type) begin
            if (r_offset < OffSrEnd) begin
                n_words[sr_word] = {r_words[sr_word][23:0], i_data_byte};
            end
        end else if (r_type == i_cfg.source_desc_type) begin
            if (r_offset < OffSdesEnd) begin
                n_words[0] = {r_words[0][23:0], i_data_byte};
            end else if (r_offset == OffItemType) begin
                n_item_type = i_data_byte;
            end else if (r_offset == OffItemLen) begin
                n_item_len = i_data_byte;
            end
        end

        done   = (r_offset >= OffLenLow) && (r_offset == last_off);
        o_emit = done && (r_seen < SeenWidth'(MAX_PACKETS));

        n_offset = done ? '0 : r_offset + 1'b1;
        n_seen   = o_emit ? r_seen + 1'b1 : r_seen;
        // end of payload restarts packet framing
        if (i_end_of_payload) begin
            n_offset = '0;
            n_seen   = '0;
        end

        o_result.header_byte     = n_header;
        o_result.packet_type     = n_type;
        o_result.length_words    = n_length;
        o_result.source_id       = n_words[0];
        o_result.ntp_high        = n_words[1];
        o_result.ntp_low         = n_words[2];
        o_result.media_timestamp = n_words[3];
        o_result.sender_packets  = n_words[4];
        o_result.sender_octets   = n_words[5];
        o_result.item_type       = n_item_type;
        o_result.item_length     = n_item_len;
        o_result.packet_index    = r_seen[3:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_seen   <= '0;
        end else if (i_advance) begin
            r_offset <= n_offset;
            r_seen   <= n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_header    <= n_header;
            r_type      <= n_type;
            r_length    <= n_length;
            r_item_type <= n_item_type;
            r_item_len  <= n_item_len;
            for (int k = 0; k < NumWords; k++) begin
                r_words[k] <= n_words[k];
            end
        end
    end

endmodule

// ===== design/rtcp_compound_packet_parser_top.sv =====
`timescale 1ns / 1ps

// RTCP compound packet parser. Takes one payload byte per transaction on the slave
// side (tlast on the final byte of the payload) and presents one transaction on the
// master side per completed RTCP packet, carrying its header and, for sender reports
// and source descriptions, the captured SSRC/timestamp/count or first SDES item.
// Throughput is one byte per clock while the slave side is not stalled: the offset
// counter and field capture update on each accepted byte. A single result register
// sits on the master side; while it holds a result that the master side has not
// taken, the slave side stalls, and it takes the next byte in the same cycle the
// waiting result is accepted. A result appears in the cycle after the packet's last
// byte. Truncated packets give no result; packets after the first MAX_PACKETS of a
// payload are skipped. Configuration writes take effect on the next byte.

module rtcp_compound_packet_parser_top
    import rtcp_types_pkg::*;
#(
    parameter int MAX_PACKETS = MaxPacketsDefault
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_addr,
    input  logic [7:0]           i_cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // data_byte
    input  logic                 s_axis_tlast,   // end_of_payload
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // header_byte, packet_type, length_words, source_id, ntp_high, ntp_low,
    // media_timestamp, sender_packets, sender_octets, item_type, item_length,
    // packet_index, zero pad
    output logic [TdataBits-1:0] m_axis_tdata
);

    t_cfg    r_cfg;
    t_result r_out;
    logic    r_out_valid;
    logic    in_fire;
    logic    emit;
    t_result result;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sender_report_type <= SenderReportReset;
            r_cfg.source_desc_type   <= SourceDescReset;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CfgSenderReport: r_cfg.sender_report_type <= i_cfg_wdata;
                CfgSourceDesc:   r_cfg.source_desc_type   <= i_cfg_wdata;
                default:         r_cfg <= r_cfg;
            endcase
        end
    end

    rtcp_parser #(
        .MAX_PACKETS (MAX_PACKETS)
    ) u_parser (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_advance        (in_fire),
        .i_data_byte      (s_axis_tdata),
        .i_end_of_payload (s_axis_tlast),
        .i_cfg            (r_cfg),
        .o_emit           (emit),
        .o_result         (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire && emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && emit) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(TdataBits - ResultBits)'(0), r_out};

endmodule
